@@ src/wbps_pkg.sv @@
// shared types and constants for the wildcard byte pattern scanner
package wbps_pkg;

    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_WORDS  = 4;
    localparam int PAT_BITS   = PAT_WORDS * CFG_DATA_W;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd4;

    // pattern byte that matches anything ('?')
    localparam logic [BYTE_W-1:0] WILDCARD = 8'h3F;

    // pattern as seen by the compare logic, length already clamped
    typedef struct packed {
        logic [PAT_BITS-1:0] bytes;
        logic [LEN_W-1:0]    len;
    } t_pattern;

endpackage

@@ src/wbps_cfg.sv @@
// pattern and length registers with the configuration write port
module wbps_cfg
    import wbps_pkg::*;
#(
    parameter int PAT_MAX = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_pattern              o_pat
);

    logic [CFG_DATA_W-1:0] r_word [PAT_WORDS];
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      eff_len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < PAT_WORDS; w++) begin
                r_word[w] <= '0;
            end
            r_len <= LEN_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PAT_WORD0: r_word[0] <= i_cfg_data;
                REG_PAT_WORD1: r_word[1] <= i_cfg_data;
                REG_PAT_WORD2: r_word[2] <= i_cfg_data;
                REG_PAT_WORD3: r_word[3] <= i_cfg_data;
                REG_PAT_LEN:   r_len     <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // zero means one, anything past the window means the whole window
    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > LEN_W'(PAT_MAX)) begin
            eff_len = LEN_W'(PAT_MAX);
        end else begin
            eff_len = r_len;
        end
    end

    assign o_pat.bytes = {r_word[3], r_word[2], r_word[1], r_word[0]};
    assign o_pat.len   = eff_len;

endmodule

@@ src/wbps_match.sv @@
// aligns the byte window to the pattern length and compares all bytes in parallel
module wbps_match
    import wbps_pkg::*;
#(
    parameter int PAT_MAX = 32
) (
    input  logic [PAT_MAX*BYTE_W-1:0] i_win,
    input  t_pattern                  i_pat,
    output logic                      o_hit
);

    localparam int WIN_W = PAT_MAX * BYTE_W;

    logic [LEN_W-1:0]   sh_bytes;
    logic [WIN_W-1:0]   aligned;
    logic [PAT_MAX-1:0] ok;

    // newest byte sits at the top; the last len bytes move down to byte 0
    assign sh_bytes = LEN_W'(PAT_MAX) - i_pat.len;
    assign aligned  = i_win >> {sh_bytes, 3'b000};

    for (genvar j = 0; j < PAT_MAX; j++) begin : g_cmp
        logic [BYTE_W-1:0] pb;
        assign pb    = i_pat.bytes[j*BYTE_W +: BYTE_W];
        assign ok[j] = (LEN_W'(j) >= i_pat.len) || (pb == WILDCARD)
                       || (pb == aligned[j*BYTE_W +: BYTE_W]);
    end

    assign o_hit = &ok;

endmodule

@@ src/wildcard_byte_pattern_scan_top.sv @@
// top level of the wildcard byte pattern scanner
// Scans a byte stream region by region and reports the absolute address of every
// non-overlapping occurrence of a programmed pattern of 1 to PAT_MAX bytes, where a
// pattern byte of 0x3F matches any byte. A request with tuser set opens a new region
// and its region_base becomes the address of that byte; bytes before the first region
// start belong to a region at address 0. A match must lie wholly inside its region,
// and after a match the next PAT_LEN - 1 bytes cannot end another one. Addresses wrap
// modulo 2^32. One byte is taken per clock cycle while the result register is free or
// is being taken; the whole-window compare and address add work on the byte while it
// sits in the input register, and the result register is loaded when that byte moves
// on. Throughput is set by the single parallel compare of the window against the
// pattern. Bytes that finish no match produce no result. Pattern registers
// are written on the configuration channel (index 0..3 pattern words, byte 0 lowest;
// index 4 length, 0 read as 1 and values above PAT_MAX read as PAT_MAX); write them
// only while the stream is idle.
module wildcard_byte_pattern_scan_top
    import wbps_pkg::*;
#(
    parameter int PAT_MAX = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // stream in
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [39:0]           i_s_tdata,   // data_byte[7:0], region_base[39:8]
    input  logic                  i_s_tuser,   // region_start
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // stream out
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [ADDR_W-1:0]     o_m_tdata    // match_addr[31:0]
);

    localparam int WIN_W = PAT_MAX * BYTE_W;

    t_pattern pat;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;
    logic [ADDR_W-1:0] r_in_base;

    // scan state
    logic [WIN_W-1:0]  r_win;
    logic [ADDR_W-1:0] r_offset;
    logic [LEN_W-1:0]  r_skip;
    logic [ADDR_W-1:0] r_base;

    // result register
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;

    logic              advance;
    logic [WIN_W-1:0]  n_win;
    logic [ADDR_W-1:0] n_offset;
    logic [LEN_W-1:0]  n_skip;
    logic [ADDR_W-1:0] base_cur;
    logic [LEN_W-1:0]  skip_cur;
    logic              in_reach;
    logic              hit;
    logic              found;
    logic [ADDR_W-1:0] match_addr;

    wbps_cfg #(.PAT_MAX(PAT_MAX)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pat       (pat)
    );

    // the byte in the input register moves on once the result slot is free
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_tdata[BYTE_W-1:0];
            r_in_base  <= i_s_tdata[BYTE_W +: ADDR_W];
            r_in_start <= i_s_tuser;
        end
    end

    // window shifts toward byte 0, newest byte enters at the top
    if (PAT_MAX > 1) begin : g_win_shift
        assign n_win = {r_in_byte, r_win[WIN_W-1:BYTE_W]};
    end else begin : g_win_single
        assign n_win = r_in_byte;
    end

    // a region start restarts the offset, the skip count and the base
    assign base_cur = r_in_start ? r_in_base : r_base;
    assign skip_cur = r_in_start ? '0 : r_skip;
    assign n_offset = (r_in_start ? '0 : r_offset) + ADDR_W'(1);

    // bytes from before the region start cannot make a match: the offset gate holds it back
    assign in_reach = n_offset >= ADDR_W'(pat.len);

    wbps_match #(.PAT_MAX(PAT_MAX)) u_match (
        .i_win (n_win),
        .i_pat (pat),
        .o_hit (hit)
    );

    assign found      = (skip_cur == '0) && in_reach && hit;
    assign match_addr = base_cur + n_offset - ADDR_W'(pat.len);

    always_comb begin
        if (skip_cur != '0) begin
            n_skip = skip_cur - LEN_W'(1);
        end else if (found) begin
            n_skip = pat.len - LEN_W'(1);
        end else begin
            n_skip = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_skip   <= '0;
            r_base   <= '0;
        end else if (advance) begin
            r_offset <= n_offset;
            r_skip   <= n_skip;
            r_base   <= base_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_win <= n_win;
        end
    end

    // result register, held until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= found;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && found) begin
            r_out_addr <= match_addr;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_addr;

endmodule

@@ test/wildcard_byte_pattern_scan_top_test.sv @@
// testbench for wildcard_byte_pattern_scan_top: random bursty byte stream, self-checking
`timescale 1ns / 1ps

module wildcard_byte_pattern_scan_top_test;
    import wbps_pkg::*;

    localparam int PAT_MAX       = 32;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the block up
    localparam int DRAIN_LIMIT   = 5000;  // cycles allowed for results to drain per phase
    localparam int SETTLE_CYCLES = 8;     // quiet cycles at the end of each idle wait

    // one stream request as the block sees it
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic              start;
        logic [BYTE_W-1:0] data;
    } t_scan_req;

    // receiver stall behavior, changes when its random mode count runs out
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_HALF,
        RDY_MOSTLY,
        RDY_RARE
    } t_ready_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [39:0]           i_s_tdata;   // data_byte[7:0], region_base[39:8]
    logic                  i_s_tuser;   // region_start
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [ADDR_W-1:0]     o_m_tdata;   // match_addr[31:0]

    wildcard_byte_pattern_scan_top #(
        .PAT_MAX(PAT_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // scanner state as this bench tracks it
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] scan_pat_word [PAT_WORDS] = '{default: '0};
    logic [LEN_W-1:0]      scan_pat_len              = 6'd1;
    logic [BYTE_W-1:0]     scan_window   [PAT_MAX]   = '{default: '0};
    logic [ADDR_W-1:0]     scan_offset               = '0;
    logic [LEN_W-1:0]      scan_skip                 = '0;
    logic [ADDR_W-1:0]     scan_base                 = '0;

    logic [ADDR_W-1:0] match_addr_q [$];  // match addresses still to come out
    t_scan_req         scan_req_q   [$];  // requests not yet handed to the driver

    int pushed_cnt   = 0;
    int accepted_cnt = 0;
    int err_cnt      = 0;
    int hold_seq     = 0;  // bumped by the sequencer to ask for a hold-off

    // length in use: zero reads as one, anything above PAT_MAX as PAT_MAX
    function automatic int eff_len();
        int n;
        n = scan_pat_len;
        if (n == 0) begin
            n = 1;
        end
        if (n > PAT_MAX) begin
            n = PAT_MAX;
        end
        return n;
    endfunction

    function automatic logic [BYTE_W-1:0] pat_byte(input int j);
        return scan_pat_word[j / 8][(j % 8) * 8 +: 8];
    endfunction

    // register write as the block applies it; spare indexes do nothing
    task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_PAT_WORD0, REG_PAT_WORD1, REG_PAT_WORD2, REG_PAT_WORD3: begin
                scan_pat_word[idx[1:0]] = val;
            end
            REG_PAT_LEN: begin
                scan_pat_len = val[LEN_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    // one accepted byte: shift the window, maybe queue a match address
    task automatic predict_match(input t_scan_req req);
        int  n;
        int  k;
        bit  hit;
        logic [BYTE_W-1:0] p;
        n = eff_len();
        // a region start restarts the offset, the pending skip and the base
        if (req.start) begin
            scan_offset = '0;
            scan_skip   = '0;
            scan_base   = req.base;
        end
        for (k = 0; k < PAT_MAX - 1; k++) begin
            scan_window[k] = scan_window[k + 1];
        end
        scan_window[PAT_MAX - 1] = req.data;
        scan_offset = scan_offset + 1;
        // bytes covered by the previous match cannot end a new one
        if (scan_skip != 0) begin
            scan_skip = scan_skip - 1;
            return;
        end
        // the match has to fit inside the current region
        if (scan_offset < ADDR_W'(n)) begin
            return;
        end
        hit = 1'b1;
        for (k = 0; k < n; k++) begin
            p = pat_byte(k);
            if (p != WILDCARD && p != scan_window[PAT_MAX - n + k]) begin
                hit = 1'b0;
            end
        end
        if (hit) begin
            match_addr_q = {match_addr_q, scan_base + scan_offset - ADDR_W'(n)};
            scan_skip = LEN_W'(n - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // stream driver: bursts of random length with random gaps between
    // ------------------------------------------------------------------
    t_scan_req drv_req;
    logic      drv_took;
    logic      drv_next_valid;
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            drv_took = i_s_tvalid && o_s_tready;
            if (drv_took) begin
                predict_match(drv_req);
                accepted_cnt++;
            end
            // only move on once the current request has gone through
            if (!i_s_tvalid || drv_took) begin
                drv_next_valid = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (scan_req_q.size() != 0) begin
                    drv_req        = scan_req_q.pop_front();
                    drv_next_valid = 1'b1;
                    i_s_tdata <= {drv_req.base, drv_req.data};
                    i_s_tuser <= drv_req.start;
                    if (burst_left != 0) begin
                        burst_left--;
                    end else begin
                        // end of a burst: often no gap at all
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                i_s_tvalid <= drv_next_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor and receiver stall pattern
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] mon_exp_addr;
    logic              mon_rdy;
    t_ready_mode       rdy_mode  = RDY_ALWAYS;
    int                mode_left = 0;
    int                hold_left = 0;
    int                hold_seen = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (match_addr_q.size() == 0) begin
                    $error("match_addr: expected none, actual %08h", o_m_tdata);
                    err_cnt++;
                end else begin
                    mon_exp_addr = match_addr_q.pop_front();
                    if (mon_exp_addr !== o_m_tdata) begin
                        $error("match_addr: expected %08h, actual %08h",
                               mon_exp_addr, o_m_tdata);
                        err_cnt++;
                    end
                end
            end
            // a hold-off request freezes the receiver until hold_left runs out
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                mon_rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rdy_mode  = t_ready_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end else begin
                    mode_left--;
                end
                case (rdy_mode)
                    RDY_ALWAYS: mon_rdy = 1'b1;
                    RDY_HALF:   mon_rdy = ($urandom_range(0, 1) == 1);
                    RDY_MOSTLY: mon_rdy = ($urandom_range(0, 7) != 0);
                    default:    mon_rdy = ($urandom_range(0, 5) == 0);
                endcase
            end
            i_m_tready <= mon_rdy;
        end
    end

    // ------------------------------------------------------------------
    // sequencer helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [BYTE_W-1:0] data, input logic start,
                             input logic [ADDR_W-1:0] base);
        t_scan_req req;
        req.data  = data;
        req.start = start;
        req.base  = base;
        scan_req_q = {scan_req_q, req};
        pushed_cnt++;
    endtask

    // register write over the config channel, only ever while idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_cfg(idx, val);
    endtask

    // all requests taken, every match out, then the settle wait
    task automatic wait_idle();
        int n;
        while (accepted_cnt != pushed_cnt) begin
            @(posedge i_clk);
        end
        n = 0;
        while (match_addr_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        if (match_addr_q.size() != 0) begin
            $error("match_addr: expected %08h, actual none (%0d missing)",
                   match_addr_q[0], match_addr_q.size());
            err_cnt++;
            match_addr_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random pattern words, a write to a spare index, then the length
    task automatic program_pattern(input logic [LEN_W-1:0] len_val, input int wild_pct);
        logic [CFG_DATA_W-1:0] word;
        int w;
        int b;
        for (w = 0; w < PAT_WORDS; w++) begin
            for (b = 0; b < 8; b++) begin
                word[b * 8 +: 8] = ($urandom_range(0, 99) < wild_pct) ? WILDCARD
                                                                      : BYTE_W'($urandom);
            end
            cfg_write(CFG_IDX_W'(REG_PAT_WORD0 + w), word);
        end
        cfg_write(CFG_IDX_W'(REG_PAT_LEN + $urandom_range(1, 3)), {$urandom, $urandom});
        // upper data bits are don't-care for the length register
        word              = {$urandom, $urandom};
        word[LEN_W-1:0]   = len_val;
        cfg_write(REG_PAT_LEN, word);
    endtask

    function automatic logic [ADDR_W-1:0] pick_base();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 40);  // wraps inside region
            default: return $urandom;
        endcase
    endfunction

    // one region: planted occurrences, spoiled ones and filler, cut to length
    task automatic push_region(input logic [ADDR_W-1:0] base, input int n_bytes,
                               input bit opens);
        logic [BYTE_W-1:0] body [$];
        logic [BYTE_W-1:0] p;
        int n;
        int j;
        int r;
        int bad;
        n = eff_len();
        while (body.size() < n_bytes) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
                bad = (r == 0) ? $urandom_range(0, n - 1) : -1;
                for (j = 0; j < n; j++) begin
                    p = pat_byte(j);
                    if (j == bad) begin
                        body = {body, p ^ (8'h01 << $urandom_range(0, 7))};
                    end else if (p == WILDCARD) begin
                        body = {body, BYTE_W'($urandom)};
                    end else begin
                        body = {body, p};
                    end
                end
            end else if ($urandom_range(0, 1) == 0) begin
                // pattern bytes as filler give near misses and partial overlaps
                body = {body, pat_byte($urandom_range(0, n - 1))};
            end else begin
                body = {body, BYTE_W'($urandom)};
            end
        end
        for (j = 0; j < n_bytes; j++) begin
            push_item(body[j], opens && j == 0, (opens && j == 0) ? base : $urandom);
        end
    endtask

    // the first region of a phase sometimes carries on the previous one
    task automatic run_phase(input int n_items);
        int sent;
        int rlen;
        int n;
        sent = 0;
        while (sent < n_items) begin
            n = eff_len();
            rlen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n + 1)
                                               : $urandom_range(n, 3 * n + 20);
            push_region(pick_base(), rlen, !(sent == 0 && $urandom_range(0, 1) == 1));
            sent += rlen;
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] phase_lens [11] = '{6'd2, 6'd3, 6'd4, 6'd8, 6'd31, 6'd32,
                                          6'd0, 6'd63, 6'd33, 6'd16, 6'd5};

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_m_tready  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset pattern is a single 0x00 byte; no region opened yet, so base 0
        push_item(8'h00, 1'b0, '0);
        push_item(8'hFF, 1'b0, '1);
        push_item(8'h00, 1'b0, '0);
        // region at the top of the address space, next match wraps to zero
        push_item(8'h00, 1'b1, 32'hFFFF_FFFF);
        push_item(8'h00, 1'b0, '0);
        // '?' in the data is just a byte
        push_item(WILDCARD, 1'b1, 32'h1234_5678);
        wait_idle();

        // all-ones words, length zero reads as one; region carries on
        cfg_write(REG_PAT_WORD0, '1);
        cfg_write(REG_PAT_WORD1, '1);
        cfg_write(REG_PAT_WORD2, '1);
        cfg_write(REG_PAT_WORD3, '1);
        cfg_write(REG_PAT_LEN, '0);
        push_item(8'hFF, 1'b0, '0);
        push_item(8'hFE, 1'b0, '0);
        wait_idle();

        // pattern 00 ? FF; a spare index write must leave it alone
        cfg_write(REG_PAT_WORD0, {40'h0, 8'hFF, WILDCARD, 8'h00});
        cfg_write(CFG_IDX_W'(REG_PAT_LEN + 3), '1);
        cfg_write(REG_PAT_LEN, 64'd3);
        push_item(8'h00, 1'b1, 32'h0000_0100);
        push_item(8'h12, 1'b0, '0);
        push_item(8'hFF, 1'b0, '0);
        // skip after a match, then a match right behind it
        push_item(8'h00, 1'b0, '0);
        push_item(WILDCARD, 1'b0, '0);
        push_item(8'hFF, 1'b0, '0);
        // partial match cut by a new region
        push_item(8'h00, 1'b0, '0);
        push_item(8'h12, 1'b0, '0);
        push_item(8'hFF, 1'b1, 32'h0000_0200);
        push_item(8'h00, 1'b0, '0);
        push_item(8'h00, 1'b0, '0);
        push_item(8'hFF, 1'b0, '0);
        wait_idle();

        // every byte matches, receiver holds off: the block has to stall its input
        program_pattern(6'd1, 100);
        hold_seq++;
        run_phase(200);
        wait_idle();

        foreach (phase_lens[i]) begin
            program_pattern(phase_lens[i], $urandom_range(0, 40));
            run_phase(120);
            wait_idle();
        end

        if (err_cnt == 0) begin
            $display("wildcard_byte_pattern_scan_top test passed");
        end else begin
            $display("wildcard_byte_pattern_scan_top test failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("wildcard_byte_pattern_scan_top test failed");
        $finish;
    end

endmodule
